// ===== sv/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, codes, constants and helpers of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int unsigned MAX_KEYS_DEF = 16;
  localparam int unsigned MW           = 49;

  localparam logic signed [23:0] ONE_Q16  = 24'sh010000;
  localparam logic signed [23:0] MAX24    = 24'sh7fffff;
  localparam logic signed [23:0] MIN24    = 24'sh800000;
  localparam logic [46:0]        PROD_CAP = 47'h4000_0000_0000;

  typedef enum logic [1:0] {
    CMD_EVAL = 2'd0,
    CMD_INS  = 2'd1,
    CMD_REM  = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_IDX  = 2'd2,
    STAT_ZERO_SEG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_HERMITE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ED_NONE,
    ED_INS,
    ED_REM
  } edit_e;

  typedef enum logic [3:0] {
    MS_U2,
    MS_U3,
    MS_M0,
    MS_M1,
    MS_H00,
    MS_H10,
    MS_H01,
    MS_H11,
    MS_LIN
  } mul_step_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_SEL,
    S_CHK,
    S_DIV,
    S_MSTART,
    S_MWAIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic signed [23:0] t;
    logic signed [23:0] v;
    logic signed [23:0] tin;
    logic signed [23:0] tout;
  } key_t;

  typedef struct packed {
    key_t lo;
    key_t hi;
    logic last;
  } seg_t;

  typedef struct packed {
    edit_e      op;
    key_t       key;
    logic [3:0] idx;
  } cell_ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] x);
    logic signed [23:0] r;
    if (x > 50'(MAX24)) begin
      r = MAX24;
    end else if (x < 50'(MIN24)) begin
      r = MIN24;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/kce_in_if.sv =====
// ----------------------------------------------------------------------------
// kce_in_if
// Command item channel of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
interface kce_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [23:0] time_point;
  logic signed [23:0] key_value_in;
  logic signed [23:0] key_in_tangent_in;
  logic signed [23:0] key_out_tangent_in;
  logic [3:0]         key_index;

  modport source (output valid, command, time_point, key_value_in, key_in_tangent_in,
                  key_out_tangent_in, key_index, input ready);
  modport sink (input valid, command, time_point, key_value_in, key_in_tangent_in,
                key_out_tangent_in, key_index, output ready);
endinterface

// ===== sv/kce_out_if.sv =====
// ----------------------------------------------------------------------------
// kce_out_if
// Result item channel of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
interface kce_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] result_value;
  logic [1:0]         status;
  logic [4:0]         stored_keys;

  modport source (output valid, result_value, status, stored_keys, input ready);
  modport sink (input valid, result_value, status, stored_keys, output ready);
endinterface

// ===== sv/kce_cell.sv =====
// ----------------------------------------------------------------------------
// kce_cell
// One key slot of the sorted key chain: holds a key, shifts on insert/remove
// and flags itself as the lower end of the segment holding the query time.
// ----------------------------------------------------------------------------
module kce_cell import kce_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [CW-1:0] count_i,
  input  key_t       left_key_i,
  input  logic       left_lt_i,
  input  key_t       right_key_i,
  input  logic       right_le_i,
  input  logic       right_valid_i,
  output key_t       key_o,
  output logic       lt_o,
  output logic       le_o,
  output logic       valid_o,
  output logic       sel_o,
  output seg_t       seg_o
);

  localparam int unsigned XW = CW + 4;

  key_t key_q, key_d;
  logic valid, lt, le, sel;

  assign valid = CW'(IDX) < count_i;
  assign lt    = valid && (key_q.t < ctrl_i.key.t);
  assign le    = valid && (key_q.t <= ctrl_i.key.t);
  assign sel   = valid && ((IDX == 0) || le) && !right_le_i;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.op)
      ED_INS: begin
        if (!lt) begin
          key_d = ((IDX == 0) || left_lt_i) ? ctrl_i.key : left_key_i;
        end
      end
      ED_REM: begin
        if (XW'(IDX) >= XW'(ctrl_i.idx)) begin
          key_d = right_key_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign lt_o    = lt;
  assign le_o    = le;
  assign valid_o = valid;
  assign sel_o   = sel;
  assign seg_o   = sel ? seg_t'{lo: key_q, hi: right_key_i, last: !right_valid_i} : '0;

endmodule

// ===== sv/kce_div.sv =====
// ----------------------------------------------------------------------------
// kce_div
// Bit-serial restoring divider for the segment fraction (mag << 16) / dt,
// one quotient bit per cycle, with an overflow flag for quotients >= 2^24.
// ----------------------------------------------------------------------------
module kce_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [24:0] mag_i,
  input  logic [23:0] div_i,
  output logic        done_o,
  output logic [23:0] q_o,
  output logic        ovf_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [24:0] rem_q, rem_d, trial;
  logic [23:0] sh_q, sh_d, q_q, q_d, div_q, div_d;
  logic        ovf_q, ovf_d, ge;

  assign trial = {rem_q[23:0], sh_q[23]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    q_d    = q_q;
    div_d  = div_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = 25'(mag_i[24:8]);
      ovf_d  = 25'(mag_i[24:8]) >= {1'b0, div_i};
      sh_d   = {mag_i[7:0], 16'b0};
      q_d    = '0;
      div_d  = div_i;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, div_q} : trial;
      q_d   = {q_q[22:0], ge};
      sh_d  = {sh_q[22:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    q_q   <= q_d;
    div_q <= div_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign ovf_o  = ovf_q;

endmodule

// ===== sv/kce_qmul.sv =====
// ----------------------------------------------------------------------------
// kce_qmul
// Sequential Q16 multiplier: four 24x24 partial products accumulated in turn,
// result (|a*b| >> 16) capped at 2^46 with the sign restored.
// ----------------------------------------------------------------------------
module kce_qmul import kce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [MW-1:0] a_i,
  input  logic signed [MW-1:0] b_i,
  output logic                 done_o,
  output logic signed [47:0]   r_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [47:0] ma_q, ma_d, mb_q, mb_d, pp;
  logic [23:0] la, lb;
  logic        neg_q, neg_d;
  logic [95:0] acc_q, acc_d, pp_sh;
  logic [MW-1:0] abs_a, abs_b;
  logic [79:0] hi;
  logic [46:0] m;

  assign abs_a = a_i[MW-1] ? MW'(-a_i) : MW'(a_i);
  assign abs_b = b_i[MW-1] ? MW'(-b_i) : MW'(b_i);
  assign la    = cnt_q[0] ? ma_q[47:24] : ma_q[23:0];
  assign lb    = cnt_q[1] ? mb_q[47:24] : mb_q[23:0];
  assign pp    = la * lb;

  always_comb begin
    case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
      2'd0:    pp_sh = {48'b0, pp};
      2'd1:    pp_sh = {24'b0, pp, 24'b0};
      2'd2:    pp_sh = {pp, 48'b0};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ma_d   = abs_a[47:0];
      mb_d   = abs_b[47:0];
      neg_d  = a_i[MW-1] ^ b_i[MW-1];
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
  end

  assign hi     = acc_q[95:16];
  assign m      = (hi > 80'(PROD_CAP)) ? PROD_CAP : hi[46:0];
  assign r_o    = neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m});
  assign done_o = done_q;

endmodule

// ===== sv/keyframe_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator
// Sorted keyframe table in a chain of key cells with step, linear and cubic
// Hermite evaluation.
// insert, remove, clear and empty evaluate go straight to the result; step, last-key
// and zero-length evaluate return after the segment check; linear and Hermite wait on
// the bit-serial divider and then the shared multiplier (1 product for linear,
// 8 for Hermite)
// throughput: one item at a time, the next taken as the result goes valid
// reset clears key count and control, sets interp_mode to linear
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator import kce_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kce_in_if.sink      in_i,
  kce_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned XW = CW + 5;

  state_e             state_q, state_d;
  logic [1:0]         mode_q;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         cmd_q, cmd_d;
  logic signed [23:0] time_q, time_d, val_q, val_d, tin_q, tin_d, tout_q, tout_d;
  logic [3:0]         kidx_q, kidx_d;
  seg_t               seg_q, seg_d, seg_or;
  logic signed [24:0] dt_q, dt_d, dt_w;
  logic signed [25:0] diff_w;
  logic [24:0]        mag_w;
  logic               neg_q, neg_d;
  logic signed [23:0] u_q, u_d, u_w;
  logic signed [47:0] u2_q, u2_d, u3_q, u3_d, m0_q, m0_d, m1_q, m1_d;
  logic signed [49:0] acc_q, acc_d;
  mul_step_e          mstep_q, mstep_d;
  logic signed [23:0] res_q, res_d, out_res_q, out_res_d;
  logic [1:0]         st_q, st_d, out_st_q, out_st_d;
  logic [4:0]         out_cnt_q, out_cnt_d;
  logic [XW-1:0]      count_x;
  cell_ctrl_t         ctrl;
  logic               div_start, div_done, div_ovf;
  logic [23:0]        div_q;
  logic               mul_start, mul_done;
  logic signed [MW-1:0] mul_a, mul_b, u_e, u2_e, u3_e, h00, h10, h01, h11;
  logic signed [47:0] mul_r;
  logic signed [23:0] tclamp;

  // ---------------------------------------------------------------- key chain
  key_t              key_w   [MAX_KEYS];
  logic              lt_w    [MAX_KEYS];
  logic              le_w    [MAX_KEYS];
  logic              valid_w [MAX_KEYS];
  seg_t              seg_w   [MAX_KEYS];
  logic [MAX_KEYS-1:0] sel_w;

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    key_t lkey, rkey;
    logic llt, rle, rvalid;
    if (g == 0) begin : g_first
      assign lkey = '0;
      assign llt  = 1'b0;
    end else begin : g_mid
      assign lkey = key_w[g-1];
      assign llt  = lt_w[g-1];
    end
    if (g == MAX_KEYS - 1) begin : g_last
      assign rkey   = '0;
      assign rle    = 1'b0;
      assign rvalid = 1'b0;
    end else begin : g_inner
      assign rkey   = key_w[g+1];
      assign rle    = le_w[g+1];
      assign rvalid = valid_w[g+1];
    end
    kce_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_key_i   (lkey),
      .left_lt_i    (llt),
      .right_key_i  (rkey),
      .right_le_i   (rle),
      .right_valid_i(rvalid),
      .key_o        (key_w[g]),
      .lt_o         (lt_w[g]),
      .le_o         (le_w[g]),
      .valid_o      (valid_w[g]),
      .sel_o        (sel_w[g]),
      .seg_o        (seg_w[g])
    );
  end

  always_comb begin
    seg_or = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      seg_or = seg_or | seg_w[i];
    end
  end

  // ---------------------------------------------------------------- arithmetic
  assign dt_w   = 25'(seg_q.hi.t) - 25'(seg_q.lo.t);
  assign diff_w = 26'(time_q) - 26'(seg_q.lo.t);
  assign mag_w  = diff_w[25] ? 25'(-diff_w) : 25'(diff_w);

  kce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (mag_w),
    .div_i  (dt_w[23:0]),
    .done_o (div_done),
    .q_o    (div_q),
    .ovf_o  (div_ovf)
  );

  always_comb begin
    if (neg_q) begin
      u_w = (div_ovf || (div_q > 24'h800000)) ? MIN24 : 24'(-$signed({1'b0, div_q}));
    end else begin
      u_w = (div_ovf || div_q[23]) ? MAX24 : $signed(div_q);
    end
  end

  assign u_e  = MW'(u_q);
  assign u2_e = MW'(u2_q);
  assign u3_e = MW'(u3_q);
  assign h00  = (u3_e <<< 1) - ((u2_e <<< 1) + u2_e) + MW'(ONE_Q16);
  assign h10  = u3_e - (u2_e <<< 1) + u_e;
  assign h01  = ((u2_e <<< 1) + u2_e) - (u3_e <<< 1);
  assign h11  = u3_e - u2_e;

  always_comb begin
    case (mstep_q)
      MS_U2:   begin mul_a = u_e;  mul_b = u_e;                                     end
      MS_U3:   begin mul_a = u2_e; mul_b = u_e;                                     end
      MS_M0:   begin mul_a = MW'(seg_q.lo.tout); mul_b = MW'(dt_q);                 end
      MS_M1:   begin mul_a = MW'(seg_q.hi.tin);  mul_b = MW'(dt_q);                 end
      MS_H00:  begin mul_a = h00;  mul_b = MW'(seg_q.lo.v);                         end
      MS_H10:  begin mul_a = h10;  mul_b = MW'(m0_q);                               end
      MS_H01:  begin mul_a = h01;  mul_b = MW'(seg_q.hi.v);                         end
      MS_H11:  begin mul_a = h11;  mul_b = MW'(m1_q);                               end
      default: begin mul_a = u_e;  mul_b = MW'(seg_q.hi.v) - MW'(seg_q.lo.v);       end
    endcase
  end

  kce_qmul u_qmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    if (in_i.time_point[23]) begin
      tclamp = '0;
    end else if (in_i.time_point > ONE_Q16) begin
      tclamp = ONE_Q16;
    end else begin
      tclamp = in_i.time_point;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign count_x    = XW'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    time_d      = time_q;
    val_d       = val_q;
    tin_d       = tin_q;
    tout_d      = tout_q;
    kidx_d      = kidx_q;
    seg_d       = seg_q;
    dt_d        = dt_q;
    neg_d       = neg_q;
    u_d         = u_q;
    u2_d        = u2_q;
    u3_d        = u3_q;
    m0_d        = m0_q;
    m1_d        = m1_q;
    acc_d       = acc_q;
    mstep_d     = mstep_q;
    res_d       = res_q;
    st_d        = st_q;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    ctrl.op     = ED_NONE;
    ctrl.key    = '{t: time_q, v: val_q, tin: tin_q, tout: tout_q};
    ctrl.idx    = kidx_q;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.command;
          time_d  = (in_i.command == CMD_EVAL) ? tclamp : in_i.time_point;
          val_d   = in_i.key_value_in;
          tin_d   = in_i.key_in_tangent_in;
          tout_d  = in_i.key_out_tangent_in;
          kidx_d  = in_i.key_index;
          state_d = (in_i.command == CMD_EVAL) ? S_SEL : S_EDIT;
        end
      end
      S_EDIT: begin
        res_d   = '0;
        st_d    = STAT_OK;
        state_d = S_FIN;
        case (cmd_q)
          CMD_INS: begin
            if (count_q >= CW'(MAX_KEYS)) begin
              st_d = STAT_FULL;
            end else begin
              ctrl.op = ED_INS;
              count_d = count_q + 1'b1;
            end
          end
          CMD_REM: begin
            if (XW'(kidx_q) >= count_x) begin
              st_d = STAT_BAD_IDX;
            end else begin
              ctrl.op = ED_REM;
              count_d = count_q - 1'b1;
            end
          end
          CMD_CLR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_SEL: begin
        seg_d = seg_or;
        st_d  = STAT_OK;
        if (count_q == '0) begin
          res_d   = ONE_Q16;
          state_d = S_FIN;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        dt_d = dt_w;
        if (seg_q.last || (mode_q == MODE_STEP)) begin
          res_d   = seg_q.lo.v;
          state_d = S_FIN;
        end else if (dt_w <= 0) begin
          res_d   = seg_q.lo.v;
          st_d    = STAT_ZERO_SEG;
          state_d = S_FIN;
        end else begin
          div_start = 1'b1;
          neg_d     = diff_w[25];
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          u_d     = u_w;
          mstep_d = (mode_q == MODE_HERMITE) ? MS_U2 : MS_LIN;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        mul_start = 1'b1;
        state_d   = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          state_d = S_MSTART;
          case (mstep_q)
            MS_U2:  begin u2_d = mul_r; mstep_d = MS_U3;  end
            MS_U3:  begin u3_d = mul_r; mstep_d = MS_M0;  end
            MS_M0:  begin m0_d = mul_r; mstep_d = MS_M1;  end
            MS_M1:  begin m1_d = mul_r; mstep_d = MS_H00; end
            MS_H00: begin acc_d = 50'(mul_r); mstep_d = MS_H10; end
            MS_H10: begin acc_d = acc_q + 50'(mul_r); mstep_d = MS_H01; end
            MS_H01: begin acc_d = acc_q + 50'(mul_r); mstep_d = MS_H11; end
            MS_H11: begin
              res_d   = sat24(acc_q + 50'(mul_r));
              state_d = S_FIN;
            end
            default: begin
              res_d   = sat24(50'(seg_q.lo.v) + 50'(mul_r));
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_st_d    = st_q;
          out_cnt_d   = count_x[4:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_LINEAR;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && !paddr[2]) begin
        mode_q <= pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    time_q    <= time_d;
    val_q     <= val_d;
    tin_q     <= tin_d;
    tout_q    <= tout_d;
    kidx_q    <= kidx_d;
    seg_q     <= seg_d;
    dt_q      <= dt_d;
    neg_q     <= neg_d;
    u_q       <= u_d;
    u2_q      <= u2_d;
    u3_q      <= u3_d;
    m0_q      <= m0_d;
    m1_q      <= m1_d;
    acc_q     <= acc_d;
    mstep_q   <= mstep_d;
    res_q     <= res_d;
    st_q      <= st_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status       = out_st_q;
  assign out_o.stored_keys  = out_cnt_q;

  assign prdata = paddr[2] ? 32'b0 : {30'b0, mode_q};
  assign pready = 1'b1;

  // ---------------------------------------------------------------- checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("key count above table depth");

  a_seg_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL) && (count_q != '0) |-> $onehot(sel_w))
    else $error("segment select not one-hot");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.command == CMD_CLR) |=> ##1 (count_q == '0))
    else $error("clear did not empty table");

  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.command == CMD_INS) && (count_q < CW'(MAX_KEYS))
    |=> ##1 (count_q == $past(count_q, 2) + 1'b1))
    else $error("insert did not grow table");

endmodule
